@@ hdl/mrtu_pkg.sv @@
// Package for the Modbus RTU master framer: mode codes, phases, timer and event codes.
// Used by all modules in hdl; depends on nothing.
package mrtu_pkg;

	localparam int unsigned BufferDepthDefault = 256;
	localparam int unsigned LenWidth = 9;
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	typedef enum logic [2:0] {
		MODE_LOAD    = 3'd0,
		MODE_START   = 3'd1,
		MODE_TXRDY   = 3'd2,
		MODE_RXBYTE  = 3'd3,
		MODE_T35     = 3'd4,
		MODE_TIMEOUT = 3'd5,
		MODE_CHECK   = 3'd6,
		MODE_ACK     = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		RX_IDLE = 2'd0,
		RX_INIT = 2'd1,
		RX_REC  = 2'd2,
		RX_ERR  = 2'd3
	} rx_phase_t;

	localparam logic [1:0] TMR_NONE    = 2'd0;
	localparam logic [1:0] TMR_RESTART = 2'd1;
	localparam logic [1:0] TMR_STOP    = 2'd2;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_SENT    = 2'd1;
	localparam logic [1:0] EV_RECEIVED = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       start;     // latch the input item and run its mode
		logic       mem_rd;    // read the buffer at the selected address
		logic [1:0] rd_sel;    // 0 read pointer, 1 trailer low, 2 trailer high, 3 read index
		logic       crc_init;
		logic       crc_step;  // fold the byte read last cycle into the CRC
		logic       crc_rd;    // read the next CRC byte
		logic       finish;    // result register is loaded
	} dp_cmd_t;

	localparam logic [1:0] RD_PTR   = 2'd0;
	localparam logic [1:0] RD_TLO   = 2'd1;
	localparam logic [1:0] RD_THI   = 2'd2;
	localparam logic [1:0] RD_INDEX = 2'd3;

	typedef struct packed {
		logic [2:0] mode;
		logic       crc_more;  // CRC byte counter below the payload length
	} dp_status_t;

endpackage

@@ hdl/mrtu_ctrl.sv @@
// Controller state machine of the Modbus RTU master framer.
// Depends on mrtu_pkg.
module mrtu_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_fire,
	input  logic                   out_busy,
	input  mrtu_pkg::dp_status_t   status,
	output logic                   in_ready,
	output mrtu_pkg::dp_cmd_t      cmd
);
	import mrtu_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_RDA  = 6'b000100,
		S_RDB  = 6'b001000,
		S_CRC  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.start = in_fire;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_EXEC;
			end
			S_EXEC: begin
				// One read: the send byte, or the trailer low byte in check mode.
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = (status.mode == MODE_CHECK) ? RD_TLO : RD_PTR;
				state_d = (status.mode == MODE_CHECK) ? S_RDA : S_DONE;
			end
			S_RDA: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RD_THI;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RD_INDEX;
				cmd.crc_init = 1'b1;
				state_d = S_CRC;
			end
			S_CRC: begin
				// Step a byte read in the prior cycle; read the next while more remain.
				cmd.crc_step = 1'b1;
				cmd.crc_rd = status.crc_more;
				if (!status.crc_more) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

@@ hdl/mrtu_dp.sv @@
// Datapath of the Modbus RTU master framer: frame buffer, pointers, phases, CRC, result.
// Depends on mrtu_pkg.
module mrtu_dp #(
	parameter int unsigned BUFFER_DEPTH = mrtu_pkg::BufferDepthDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mrtu_pkg::dp_cmd_t      cmd,
	input  logic [2:0]             in_mode,
	input  logic [7:0]             in_data,
	input  logic                   in_clear,
	input  logic [7:0]             in_index,
	output mrtu_pkg::dp_status_t   status,
	output logic [39:0]            res
);
	import mrtu_pkg::*;

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);
	localparam logic [LenWidth-1:0] Depth = LenWidth'(BUFFER_DEPTH);

	logic [7:0] mem_q [BUFFER_DEPTH];
	logic [7:0] rdata_q;

	logic [2:0] mode_q;
	logic [7:0] data_q, index_q;
	logic       clear_q;

	rx_phase_t  rx_q;
	logic       tx_q, link_q, err_q;
	logic [1:0] ev_q;
	logic [LenWidth-1:0] rp_q, wp_q, cnt_q;
	logic [15:0] crc_q;
	logic [7:0]  tlo_q, thi_q;
	logic        rd_ok_q;

	logic        tv_q, lok_q;
	logic [7:0]  rbyte_q;
	logic [1:0]  ctc_q, rtc_q;

	assign status.mode = mode_q;
	assign status.crc_more = (cnt_q + LenWidth'(2)) < wp_q;

	// Store write happens in S_EXEC for load and receive modes.
	logic wr_en;
	logic [LenWidth-1:0] wr_ptr;
	logic                exec_q;
	always_comb begin
		wr_en = 1'b0;
		wr_ptr = wp_q;
		if (exec_q) begin
			if (mode_q == MODE_LOAD) begin
				if (clear_q) wr_ptr = '0;
				wr_en = wr_ptr < Depth;
			end else if (mode_q == MODE_RXBYTE) begin
				if (rx_q == RX_INIT) wr_ptr = '0;
				wr_en = (rx_q == RX_INIT || rx_q == RX_REC) && (wr_ptr < Depth);
			end
		end
	end

	logic [LenWidth-1:0] raddr;
	always_comb begin
		unique case (cmd.rd_sel)
			RD_PTR:   raddr = rp_q;
			RD_TLO:   raddr = wp_q - LenWidth'(2);
			RD_THI:   raddr = wp_q - LenWidth'(1);
			RD_INDEX: raddr = LenWidth'(index_q);
			default:  raddr = rp_q;
		endcase
		if (cmd.crc_rd) raddr = cnt_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr[AW-1:0]] <= data_q;
		if (cmd.mem_rd || cmd.crc_rd) rdata_q <= mem_q[raddr[AW-1:0]];
	end

	// Bitwise CRC update of one byte.
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
		return x;
	endfunction

	logic [2:0] sub_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q <= RX_IDLE; tx_q <= 1'b0; link_q <= 1'b0; err_q <= 1'b0;
			ev_q <= EV_NONE; rp_q <= '0; wp_q <= '0; exec_q <= 1'b0; sub_q <= '0;
		end else begin
			exec_q <= cmd.start;
			if (cmd.start) sub_q <= '0;
			else if (sub_q != 3'd7) sub_q <= sub_q + 3'd1;
			if (exec_q) begin
				unique case (mode_q)
					MODE_LOAD: begin
						if (clear_q) rp_q <= '0;
						wp_q <= wr_en ? wr_ptr + LenWidth'(1) : wr_ptr;
					end
					MODE_START: tx_q <= 1'b1;
					MODE_TXRDY: begin
						if (tx_q) begin
							if (rp_q < wp_q) rp_q <= rp_q + LenWidth'(1);
							else begin
								ev_q <= EV_SENT; tx_q <= 1'b0; rx_q <= RX_INIT; link_q <= 1'b1;
							end
						end
					end
					MODE_RXBYTE: begin
						if (rx_q == RX_INIT) begin
							rp_q <= '0; wp_q <= LenWidth'(1); rx_q <= RX_REC;
						end else if (rx_q == RX_REC) begin
							if (wr_en) wp_q <= wp_q + LenWidth'(1);
							else rx_q <= RX_ERR;
						end
					end
					MODE_T35: begin
						if (rx_q != RX_IDLE) begin
							ev_q <= (rx_q == RX_REC) ? EV_RECEIVED : EV_NONE;
							rx_q <= RX_IDLE; link_q <= 1'b0;
						end
					end
					MODE_TIMEOUT: begin
						if (ev_q == EV_SENT) begin
							err_q <= 1'b1; ev_q <= EV_NONE; link_q <= 1'b0;
						end
					end
					MODE_CHECK: ;
					MODE_ACK: begin
						ev_q <= EV_NONE; err_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// Per-item result fields, decided in the execute cycle from the state before it.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= in_mode; data_q <= in_data; clear_q <= in_clear; index_q <= in_index;
		end
		if (exec_q) begin
			tv_q <= (mode_q == MODE_TXRDY) && tx_q && (rp_q < wp_q);
			lok_q <= (mode_q == MODE_LOAD) && wr_en;
			ctc_q <= (mode_q == MODE_RXBYTE && rx_q != RX_IDLE) ? TMR_RESTART :
			         (mode_q == MODE_T35) ? TMR_STOP : TMR_NONE;
			rtc_q <= (mode_q == MODE_TXRDY && tx_q) ? TMR_RESTART :
			         (mode_q == MODE_TIMEOUT) ? TMR_STOP : TMR_NONE;
			rd_ok_q <= LenWidth'(index_q) < wp_q;
		end
		// Read data order in check mode: trailer low, trailer high, indexed byte.
		if (sub_q == 3'd1) tlo_q <= rdata_q;
		if (sub_q == 3'd2) thi_q <= rdata_q;
		if (sub_q == 3'd3) rbyte_q <= rd_ok_q ? rdata_q : 8'h00;
		// The counter addresses the byte being read; the fold takes the one read before it.
		if (cmd.crc_init) begin
			crc_q <= CrcInit; cnt_q <= '0;
		end else if (cmd.crc_step) begin
			if (cnt_q != '0 && cnt_q + LenWidth'(2) <= wp_q)
				crc_q <= crc_byte(crc_q, rdata_q);
			cnt_q <= cnt_q + LenWidth'(1);
		end
	end

	// Final CRC compare; the CRC of an empty payload is its initial value.
	// The send byte stays in the read register until the result is taken.
	logic check_mode;
	assign check_mode = (mode_q == MODE_CHECK);
	always_comb begin
		logic ok;
		ok = check_mode && (wp_q >= LenWidth'(2)) &&
		     (((wp_q == LenWidth'(2)) ? CrcInit : crc_q) == {thi_q, tlo_q});
		res = {4'h0, lok_q, (check_mode ? rbyte_q : 8'h00), wp_q, ok, err_q, ev_q, rtc_q,
		       ctc_q, link_q, (tv_q ? rdata_q : 8'h00), tv_q};
	end
endmodule

@@ hdl/modbus_rtu_master_framer.sv @@
// Top level of the Modbus RTU master framer: stream ports and output register.
// Depends on mrtu_pkg, mrtu_ctrl and mrtu_dp.
//
// Each input transaction carries one command (load, start send, transmitter ready, received
// byte, 3.5-character expiry, response timeout, frame check, acknowledge) and yields exactly one
// result transaction with the link direction, timer commands, event, error flag and buffer length.
// A simple command passes through execute and finish after its accepting edge, and its result
// is registered at finish; the next command is accepted only once the controller is idle again.
// A frame check of a buffer of N bytes, N at least two, passes through execute (trailer low
// read), a trailer high read, an indexed byte read, a CRC walk over the payload and finish; a
// shorter buffer passes the same states with no byte folded. The walk is set by the single
// read port of the frame buffer, which it reads one byte per cycle. A command waits in its
// finish cycle as long as the result register is full and not being read. The buffer needs
// no clearing after reset; the result register lets the next command enter while a result waits.
module modbus_rtu_master_framer #(
	parameter int unsigned BUFFER_DEPTH = mrtu_pkg::BufferDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // mode[2:0], data_byte[10:3], clear_first[11], read_index[19:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // tx_valid, tx_byte, receive_direction, char_timer_cmd,
	                              // reply_timer_cmd, master_event, timeout_error, frame_ok,
	                              // frame_length, read_byte, load_ok
);
	import mrtu_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready, in_fire;
	logic [39:0] res;

	assign s_tready = in_ready;
	assign in_fire = s_tvalid && s_tready;

	// The controller waits in its final state while the result register is full and not being read.
	mrtu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(m_tvalid && !m_tready), .status(status),
		.in_ready(in_ready), .cmd(cmd)
	);

	mrtu_dp #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_mode(s_tdata[2:0]), .in_data(s_tdata[10:3]), .in_clear(s_tdata[11]),
		.in_index(s_tdata[19:12]), .status(status), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (cmd.finish) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) m_tdata <= res;
	end
endmodule
